// ===== rtl/core/chol_pkg.sv =====
// Shared types and constants for the Cholesky factorization block.
package chol_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned AddrW = 6;
  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusAsym = 2'd1;
  localparam logic [1:0] StatusPivot = 2'd2;
  localparam logic [1:0] RegMatrixSize = 2'd0;

  typedef enum logic [11:0] {
    S_LOAD  = 12'b000000000001,
    S_SYMA  = 12'b000000000010,
    S_SYMB  = 12'b000000000100,
    S_SYMC  = 12'b000000001000,
    S_FRDA  = 12'b000000010000,
    S_FRDB  = 12'b000000100000,
    S_FMAC  = 12'b000001000000,
    S_FACC  = 12'b000010000000,
    S_FRES  = 12'b000100000000,
    S_FDIV  = 12'b001000000000,
    S_EMIT  = 12'b010000000000,
    S_ERR   = 12'b100000000000
  } state_t;
endpackage

// ===== rtl/core/chol_ram.sv =====
// Generic single-port-write, one-read synchronous RAM with registered read.
module chol_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/cholesky_factorization.sv =====
// Top level of the Cholesky factorization block.
//
// Load an n-by-n signed Q16.16 matrix with start/a_value, one element per beat,
// row-major. busy is low during loading, so one element may be given each cycle.
// The beat that completes the matrix starts a run: busy rises, the symmetry check
// reads every pair, then the factor is built entry by entry. Each product sum
// term takes two memory reads and one multiply, each off-diagonal entry a
// restoring divide, each diagonal entry a square root. The single read port of
// each memory sets the pace of a run. Results follow as n*n beats on consecutive
// cycles, each marked by valid for one cycle, last_result on the final beat; an
// error gives one beat with status 1 (not symmetric) or 2 (pivot not positive).
// The receiver cannot stall. Writing matrix_size over APB (address 0) restarts
// the load. Reset sets matrix_size to 8, clears the load count and returns to
// loading; the matrix memories are not cleared.
module cholesky_factorization #(
  parameter int unsigned MAX_ORDER = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic signed [31:0] a_value,
  output logic        valid,
  output logic signed [31:0] l_value,
  output logic [2:0]  row_index,
  output logic [2:0]  col_index,
  output logic [1:0]  status,
  output logic        last_result
);
  localparam int unsigned MaxN = (MAX_ORDER > 8) ? 8 : ((MAX_ORDER < 1) ? 1 : MAX_ORDER);

  chol_pkg::state_t state;
  logic [3:0] matrix_size;
  logic [3:0] n;
  logic [6:0] load_count;
  logic [6:0] nn;
  logic [2:0] ri, ci, ki;
  logic signed [63:0] sum;
  logic signed [31:0] opa;
  logic t_neg;
  logic [6:0] step;
  logic [63:0] rem;
  logic [63:0] quo;
  logic [32:0] den;
  logic [31:0] sq_res;
  logic [35:0] sq_rem;
  logic [47:0] sq_x;

  logic a_we, f_we;
  logic [5:0] a_waddr, f_waddr, a_raddr, f_raddr;
  logic [31:0] a_wdata, f_wdata, a_rdata, f_rdata;

  chol_ram #(.Width(32), .Depth(64)) u_amem (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .raddr(a_raddr), .rdata(a_rdata));
  chol_ram #(.Width(32), .Depth(64)) u_fmem (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_rdata));

  always_comb begin
    n = matrix_size;
    if (n == 4'd0) n = 4'd1;
    if (n > 4'(MaxN)) n = 4'(MaxN);
  end

  assign nn = 7'(n) * 7'(n);
  assign pready = 1'b1;
  assign prdata = {28'd0, matrix_size};
  assign busy = (state != chol_pkg::S_LOAD);

  function automatic logic [5:0] idx(input logic [2:0] r, input logic [2:0] c,
                                      input logic [3:0] nsz);
    logic [6:0] v;
    v = 7'(r) * 7'(nsz) + 7'(c);
    return v[5:0];
  endfunction

  logic wr_cfg;
  logic take;
  assign wr_cfg = psel && penable && pwrite && (paddr == chol_pkg::RegMatrixSize);
  assign take = start && !busy;

  logic signed [63:0] prod_r;
  logic [63:0] pmag;
  logic [63:0] prnd;
  logic signed [63:0] dval;
  logic signed [63:0] tval;
  logic [35:0] sq_trial;
  logic [64:0] div_trial;
  logic [63:0] q_sat;
  logic signed [31:0] div_out;
  logic [2:0] ci_next;
  logic last_col;

  always_comb begin
    pmag = prod_r[63] ? (64'd0 - 64'(prod_r)) : 64'(prod_r);
    prnd = (pmag + 64'd32768) >> 16;
    dval = 64'(signed'(a_rdata)) - sum;
    tval = dval;
    if (tval > 64'sd140737488355328) tval = 64'sd140737488355328;
    if (tval < -64'sd140737488355328) tval = -64'sd140737488355328;
    sq_trial = {sq_rem[33:0], sq_x[47:46]} - {2'b00, sq_res, 2'b01};
    div_trial = {rem, quo[63]} - {32'd0, den};
    q_sat = (quo > 64'h1_0000_0000) ? 64'h1_0000_0000 : quo;
    if (t_neg) begin
      div_out = (q_sat > 64'h8000_0000) ? 32'sh8000_0000 : 32'(64'd0 - q_sat);
    end else begin
      div_out = (q_sat > 64'h7fff_ffff) ? 32'sh7fff_ffff : 32'(q_sat);
    end
    last_col = (ci == ri);
    ci_next = ci + 3'd1;
  end

  logic [63:0] rem_next;
  assign rem_next = div_trial[64] ? {rem[62:0], quo[63]} : div_trial[63:0];

  always_ff @(posedge clk) begin
    a_we <= 1'b0;
    f_we <= 1'b0;
    valid <= 1'b0;
    if (rst) begin
      state <= chol_pkg::S_LOAD;
      matrix_size <= 4'd8;
      load_count <= 7'd0;
    end else begin
      if (wr_cfg) begin
        matrix_size <= pwdata[3:0];
        load_count <= 7'd0;
      end
      unique case (state)
        chol_pkg::S_LOAD: begin
          if (take) begin
            a_we <= 1'b1;
            a_waddr <= load_count[5:0];
            a_wdata <= a_value;
            if (load_count + 7'd1 >= nn) begin
              load_count <= 7'd0;
              ri <= 3'd0;
              ci <= 3'd1;
              ki <= 3'd0;
              state <= chol_pkg::S_SYMA;
            end else begin
              load_count <= load_count + 7'd1;
            end
          end
        end
        chol_pkg::S_SYMA: begin
          if (4'(ci) >= n || ci == 3'd0) begin
            if (4'(ri) + 4'd2 >= n) begin
              ri <= 3'd0;
              ci <= 3'd0;
              state <= chol_pkg::S_FRDA;
            end else begin
              ri <= ri + 3'd1;
              ci <= ri + 3'd2;
            end
          end else begin
            a_raddr <= idx(ri, ci, n);
            state <= chol_pkg::S_SYMB;
          end
        end
        chol_pkg::S_SYMB: begin
          a_raddr <= idx(ci, ri, n);
          state <= chol_pkg::S_SYMC;
        end
        chol_pkg::S_SYMC: begin
          opa <= a_rdata;
          state <= chol_pkg::S_ERR;
          // compare on next cycle handled by reusing S_ERR guard below
        end
        chol_pkg::S_FRDA: begin
          sum <= 64'sd0;
          ki <= 3'd0;
          if (ci == 3'd0) begin
            a_raddr <= idx(ri, ci, n);
            f_raddr <= idx(ci, ci, n);
            step <= 7'd0;
            state <= chol_pkg::S_FRES;
          end else begin
            f_raddr <= idx(ri, 3'd0, n);
            state <= chol_pkg::S_FRDB;
          end
        end
        chol_pkg::S_FRDB: begin
          f_raddr <= idx(ci, ki, n);
          state <= chol_pkg::S_FMAC;
        end
        chol_pkg::S_FMAC: begin
          opa <= f_rdata;
          state <= chol_pkg::S_FACC;
        end
        chol_pkg::S_FACC: begin
          prod_r <= opa * signed'(f_rdata);
          if (ki + 3'd1 == ci) begin
            a_raddr <= idx(ri, ci, n);
            f_raddr <= idx(ci, ci, n);
            step <= 7'd0;
            state <= chol_pkg::S_FRES;
          end else begin
            ki <= ki + 3'd1;
            f_raddr <= idx(ri, ki + 3'd1, n);
            state <= chol_pkg::S_FRDB;
          end
          if (ki != 3'd0) begin
            sum <= sum + (prod_r[63] ? -64'(signed'(prnd)) : 64'(signed'(prnd)));
          end
        end
        chol_pkg::S_FRES: begin
          if (step == 7'd0) begin
            if (ci != 3'd0) begin
              sum <= sum + (prod_r[63] ? -64'(signed'(prnd)) : 64'(signed'(prnd)));
            end
            step <= 7'd1;
          end else begin
            step <= 7'd0;
            if (ci == ri) begin
              if (dval <= 64'sd0) begin
                state <= chol_pkg::S_ERR;
                opa <= 32'sd0;
                ki <= 3'd1;
              end else begin
                sq_x <= {dval[31:0], 16'd0};
                sq_rem <= 36'd0;
                sq_res <= 32'd0;
                t_neg <= 1'b0;
                state <= chol_pkg::S_FDIV;
              end
            end else begin
              t_neg <= tval[63];
              den <= (f_rdata == 32'd0) ? 33'd1 : {1'b0, f_rdata};
              quo <= (tval[63] ? 64'(-tval) : 64'(tval)) << 16;
              rem <= 64'd0;
              state <= chol_pkg::S_FDIV;
            end
          end
        end
        chol_pkg::S_FDIV: begin
          if (ci == ri) begin
            sq_x <= {sq_x[45:0], 2'b00};
            if (!sq_trial[35]) begin
              sq_rem <= sq_trial;
              sq_res <= {sq_res[30:0], 1'b1};
            end else begin
              sq_rem <= {sq_rem[33:0], sq_x[47:46]};
              sq_res <= {sq_res[30:0], 1'b0};
            end
            step <= step + 7'd1;
            if (step == 7'd23) begin
              f_we <= 1'b1;
              f_waddr <= idx(ri, ci, n);
              f_wdata <= !sq_trial[35] ? {sq_res[30:0], 1'b1} : {sq_res[30:0], 1'b0};
              ki <= 3'd0;
              state <= chol_pkg::S_EMIT;
            end
          end else if (step < 7'd64) begin
            rem <= rem_next;
            quo <= {quo[62:0], ~div_trial[64]};
            step <= step + 7'd1;
          end else if (step == 7'd64) begin
            // round: compare 2*rem with den
            if ({rem, 1'b0} >= {32'd0, den}) quo <= quo + 64'd1;
            step <= 7'd65;
          end else begin
            f_we <= 1'b1;
            f_waddr <= idx(ri, ci, n);
            f_wdata <= div_out;
            ki <= 3'd0;
            state <= chol_pkg::S_EMIT;
          end
        end
        chol_pkg::S_EMIT: begin
          // advance the factor position, or stream results
          if (ki == 3'd7) begin
            valid <= 1'b1;
            l_value <= (ci <= ri) ? f_rdata : 32'sd0;
            row_index <= ri;
            col_index <= ci;
            status <= chol_pkg::StatusOk;
            last_result <= (4'(ri) + 4'd1 == n) && (4'(ci) + 4'd1 == n);
            f_raddr <= idx(ri, ci, n) + 6'd2;
            if (4'(ci) + 4'd1 == n) begin
              ci <= 3'd0;
              ri <= ri + 3'd1;
              if (4'(ri) + 4'd1 == n) state <= chol_pkg::S_LOAD;
            end else begin
              ci <= ci_next;
            end
          end else if (ki == 3'd6) begin
            ki <= 3'd7;
            f_raddr <= idx(3'd0, 3'd1, n);
          end else if (last_col) begin
            if (4'(ri) + 4'd1 == n) begin
              ri <= 3'd0;
              ci <= 3'd0;
              ki <= 3'd6;
              f_raddr <= 6'd0;
            end else begin
              ri <= ri + 3'd1;
              ci <= 3'd0;
              state <= chol_pkg::S_FRDA;
            end
          end else begin
            ci <= ci_next;
            state <= chol_pkg::S_FRDA;
          end
        end
        chol_pkg::S_ERR: begin
          if (ki == 3'd1) begin
            valid <= 1'b1;
            l_value <= 32'sd0;
            row_index <= ri;
            col_index <= ri;
            status <= chol_pkg::StatusPivot;
            last_result <= 1'b1;
            state <= chol_pkg::S_LOAD;
          end else if (opa != a_rdata) begin
            valid <= 1'b1;
            l_value <= 32'sd0;
            row_index <= ri;
            col_index <= ci;
            status <= chol_pkg::StatusAsym;
            last_result <= 1'b1;
            state <= chol_pkg::S_LOAD;
          end else begin
            ci <= ci + 3'd1;
            state <= chol_pkg::S_SYMA;
          end
        end
        default: state <= chol_pkg::S_LOAD;
      endcase
      if (state == chol_pkg::S_SYMA && (4'(ci) >= n || ci == 3'd0)
          && 4'(ri) + 4'd2 >= n) begin
        ki <= 3'd0;
      end
    end
  end
endmodule

// ===== sim/cholesky_factorization_tb.sv =====
// Self-checking testbench for the Cholesky factorization block: random matrices, APB sizes.
`timescale 1ns / 1ps

module cholesky_factorization_tb;
  typedef enum int {OP_ITEM, OP_CFG, OP_DRAIN, OP_PHASE} op_e;
  typedef struct {
    op_e op;
    logic [31:0] data;
  } cmd_t;
  typedef struct {
    logic [31:0] l_value;
    logic [2:0] row_index;
    logic [2:0] col_index;
    logic [1:0] status;
    logic last_result;
  } factor_beat_t;

  localparam int CycleLimit = 1500000;

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic start, busy, valid, last_result;
  logic signed [31:0] a_value, l_value;
  logic [2:0] row_index, col_index;
  logic [1:0] status;

  cmd_t cmd_q[$];
  factor_beat_t factor_q[$];
  int errors = 0;
  int cycles = 0;
  int sender_idle = 0;
  int settle = 0;

  longint mat_a[64];
  longint mat_l[64];
  int loaded = 0;
  logic [3:0] size_reg = 4'd8;

  cholesky_factorization DUT (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .a_value(a_value), .valid(valid),
    .l_value(l_value), .row_index(row_index), .col_index(col_index),
    .status(status), .last_result(last_result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int order_of(logic [3:0] v);
    if (v == 4'd0) return 1;
    if (v > 4'd8) return 8;
    return int'(v);
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint q_mul(longint a, longint b);
    longint p;
    longint unsigned r;
    p = a * b;
    r = (magnitude(p) + 64'd32768) >> 16;
    return p < 0 ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (x >= res + bit_v) begin
        x = x - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  function automatic longint sat_q(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void push_beat(longint v, int r, int c, logic [1:0] st, bit lst);
    factor_beat_t b;
    b.l_value = v[31:0];
    b.row_index = r[2:0];
    b.col_index = c[2:0];
    b.status = st;
    b.last_result = lst;
    factor_q.push_back(b);
  endfunction

  function automatic void factorise_step(logic [31:0] raw);
    int n, i, j, k;
    longint sum, res, d, t;
    longint unsigned den, q;
    n = order_of(size_reg);
    mat_a[loaded & 63] = longint'(signed'(raw));
    loaded = (loaded + 1) & 127;
    if (loaded < n * n) return;
    loaded = 0;
    for (i = 0; i < n; i++)
      for (j = i + 1; j < n; j++)
        if (mat_a[i * n + j] != mat_a[j * n + i]) begin
          push_beat(0, i, j, chol_pkg::StatusAsym, 1'b1);
          return;
        end
    for (i = 0; i < n; i++) begin
      for (j = 0; j < n; j++) begin
        if (j > i) begin
          mat_l[i * n + j] = 0;
          continue;
        end
        sum = 0;
        for (k = 0; k < j; k++) sum += q_mul(mat_l[i * n + k], mat_l[j * n + k]);
        if (i == j) begin
          d = mat_a[i * n + i] - sum;
          if (d <= 0) begin
            push_beat(0, i, i, chol_pkg::StatusPivot, 1'b1);
            return;
          end
          res = longint'(int_sqrt(longint'(d) << 16));
        end else begin
          t = mat_a[i * n + j] - sum;
          if (t > 64'sd140737488355328) t = 64'sd140737488355328;
          if (t < -64'sd140737488355328) t = -64'sd140737488355328;
          den = mat_l[j * n + j];
          if (den == 0) den = 1;
          q = ((magnitude(t) << 16) + den / 2) / den;
          if (q > 64'd4294967296) q = 64'd4294967296;
          res = t < 0 ? -longint'(q) : longint'(q);
        end
        mat_l[i * n + j] = sat_q(res);
      end
    end
    for (i = 0; i < n * n; i++)
      push_beat(mat_l[i], i / n, i % n, chol_pkg::StatusOk, i == n * n - 1);
  endfunction

  // driver
  always @(posedge clk) begin
    logic next_start;
    if (rst) begin
      start <= 1'b0;
      a_value <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
    end else begin
      next_start = start;
      if (start && !busy) begin
        factorise_step(a_value);
        void'(cmd_q.pop_front());
        next_start = 1'b0;
      end
      if (psel && penable && pwrite && pready) begin
        size_reg = pwdata[3:0];
        loaded = 0;
        void'(cmd_q.pop_front());
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
      end else if (psel) begin
        penable <= 1'b1;
      end else if (!(start && busy) && cmd_q.size() > 0) begin
        case (cmd_q[0].op)
          OP_ITEM: begin
            if ($urandom_range(99) < sender_idle) begin
              next_start = 1'b0;
            end else begin
              next_start = 1'b1;
              a_value <= cmd_q[0].data;
            end
          end
          OP_CFG: begin
            next_start = 1'b0;
            if (factor_q.size() == 0 && !busy) begin
              settle++;
              if (settle >= 16) begin
                settle = 0;
                psel <= 1'b1;
                pwrite <= 1'b1;
                paddr <= 2'(4 * chol_pkg::RegMatrixSize);
                pwdata <= cmd_q[0].data;
              end
            end else begin
              settle = 0;
            end
          end
          OP_DRAIN: begin
            next_start = 1'b0;
            if (factor_q.size() == 0 && !busy) void'(cmd_q.pop_front());
          end
          default: begin
            next_start = 1'b0;
            sender_idle = cmd_q[0].data;
            void'(cmd_q.pop_front());
          end
        endcase
      end
      start <= next_start;
    end
  end

  function automatic void report(string what, factor_beat_t w);
    errors++;
    if (errors <= 10)
      $display({"mismatch %s: expected l=%h r=%0d c=%0d st=%0d last=%0b,",
                " got l=%h r=%0d c=%0d st=%0d last=%0b"},
               what, w.l_value, w.row_index, w.col_index, w.status, w.last_result,
               l_value, row_index, col_index, status, last_result);
  endfunction

  // monitor
  always @(posedge clk) begin
    factor_beat_t w;
    if (!rst && valid) begin
      if (factor_q.size() == 0) begin
        w = '{default: '0};
        report("unexpected beat", w);
      end else begin
        w = factor_q.pop_front();
        if (l_value !== w.l_value || row_index !== w.row_index ||
            col_index !== w.col_index || status !== w.status ||
            last_result !== w.last_result)
          report("field", w);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic add(op_e op, logic [31:0] data);
    cmd_q.push_back('{op, data});
  endtask

  // kind: 0 well-formed, 1 asymmetric, 2 non-positive pivot, 3 noise, 4 large
  task automatic add_matrix(int n, int kind, inout int count);
    logic [31:0] m[64];
    int i, j;
    for (i = 0; i < n; i++)
      for (j = 0; j <= i; j++) begin
        if (i == j) begin
          m[i * n + j] = (kind == 4) ? 32'($urandom_range(32'h7FFF0000, 32'h40000000))
                                     : 32'($urandom_range(n * 128 * 65536, n * 64 * 65536));
        end else begin
          m[i * n + j] = (kind == 4) ? $urandom
                                     : 32'(int'($urandom_range(131071)) - 65536);
        end
        if (kind == 3) m[i * n + j] = $urandom;
        m[j * n + i] = m[i * n + j];
      end
    if (kind == 1 && n > 1) begin
      i = $urandom_range(n - 1, 1);
      j = $urandom_range(i - 1);
      m[j * n + i] = m[j * n + i] ^ (32'd1 << $urandom_range(31));
    end
    if (kind == 2) begin
      i = $urandom_range(n - 1);
      m[i * n + i] = $urandom_range(1) ? 32'd0 : 32'h80000000 | $urandom;
    end
    for (i = 0; i < n * n; i++) add(OP_ITEM, m[i]);
    count += n * n;
  endtask

  initial begin
    int count, n, kind, sel, phase;
    logic [3:0] cfg;
    count = 0;
    rst = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    add(OP_CFG, 32'd1);
    add(OP_ITEM, 32'h7FFFFFFF);
    add(OP_ITEM, 32'h80000000);
    add(OP_ITEM, 32'h00000000);
    add(OP_ITEM, 32'h00000001);
    add(OP_CFG, 32'd2);
    add(OP_ITEM, 32'h00010000); add(OP_ITEM, 32'h00020000);
    add(OP_ITEM, 32'h00030000); add(OP_ITEM, 32'h00040000);
    add(OP_ITEM, 32'h00000001); add(OP_ITEM, 32'h40000000);
    add(OP_ITEM, 32'h40000000); add(OP_ITEM, 32'h7FFFFFFF);
    add(OP_ITEM, 32'h00010000); add(OP_ITEM, 32'h00020000);
    add(OP_ITEM, 32'h00020000); add(OP_ITEM, 32'h00010000);
    add(OP_ITEM, 32'h12345678);
    add(OP_CFG, 32'd0);
    add(OP_ITEM, 32'h00040000);
    add(OP_DRAIN, 0);
    count = 18;

    cfg = 4'd0;
    phase = 0;
    while (count < 480) begin
      if ($urandom_range(4) == 0) begin
        case (phase % 4)
          0: add(OP_PHASE, 0);
          1: add(OP_PHASE, 62);
          2: add(OP_PHASE, 17);
          default: add(OP_PHASE, 0);
        endcase
        phase++;
      end
      sel = $urandom_range(99);
      if (sel < 8) begin
        // partial load, then a size write that restarts it
        n = order_of(cfg);
        repeat ($urandom_range(n * n - 1)) begin
          add(OP_ITEM, $urandom);
          count++;
        end
      end
      if (sel < 40) begin
        sel = $urandom_range(99);
        if (sel < 80) cfg = 4'($urandom_range(4, 1));
        else if (sel < 92) cfg = 4'($urandom_range(7, 5));
        else if (sel < 96) cfg = 4'd8;
        else cfg = $urandom_range(1) ? 4'd0 : 4'($urandom_range(15, 9));
        add(OP_CFG, 32'(cfg) | ($urandom & 32'hFFFFFFF0));
      end
      n = order_of(cfg);
      sel = $urandom_range(99);
      kind = sel < 65 ? 0 : sel < 75 ? 1 : sel < 83 ? 2 : sel < 91 ? 3 : 4;
      add_matrix(n, kind, count);
      if ($urandom_range(9) == 0) add(OP_DRAIN, 0);
    end
    add(OP_CFG, 32'd15);
    add(OP_CFG, 32'd1);
    add_matrix(1, 0, count);

    wait (cmd_q.size() == 0 && !start);
    wait (factor_q.size() == 0);
    repeat (3000) @(posedge clk);
    if (errors == 0 && factor_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/core/chol_pkg.sv
rtl/core/chol_ram.sv
rtl/core/cholesky_factorization.sv
sim/cholesky_factorization_tb.sv
